// ===== rtl/lz77td_pkg.sv =====
// lz77td_pkg: shared constants and types for the lz77 triple decoder
// no dependencies; used by the top level, the assertion checker and the bench
`timescale 1ns / 1ps

package lz77td_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int MAX_MATCH   = 63;
    localparam int ADDR_W      = $clog2(WINDOW_SIZE);
    localparam int DIST_W      = 13;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_LIT
    } t_state;

    // per-cycle control from the output decoder
    typedef struct packed {
        logic rd_en;
        logic load_copy;
        logic load_lit;
        logic rec;
    } t_ctl;

endpackage

// ===== rtl/lz77td_ram.sv =====
// lz77td_ram: generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lz77td_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lz77_triple_decoder.sv =====
// lz77_triple_decoder: top level, sequencer around one history ram
// depends on lz77td_pkg and lz77td_ram
`timescale 1ns / 1ps

// input channel: one beat per triple (distance, match length, next byte),
//   taken when i_valid is high and o_stall is low. o_stall is high while a
//   triple is being expanded, so one triple is worked on at a time.
// output channel: one beat per decoded byte, taken when o_valid is high and
//   i_stall is low. o_last marks the final byte of a triple; o_malformed
//   marks the single byte of a rejected triple.
// timing
//   the triple is taken in the idle cycle. each copied byte goes through the
//   history ram in S_READ, which issues the read address, then in S_WAIT,
//   which catches the registered read data into the output register and
//   writes it back into history. the literal is then loaded in S_LIT; a
//   literal or a rejected triple goes straight from idle to S_LIT.
// stalls: a stalled output beat holds; the sequencer waits with its read data
//   held in the ram output register and resumes when the beat goes.
// reset: i_rst_n clears the sequencer, output valid, fill value, byte count,
//   write pointer and the started flag. history is not cleared: positions
//   beyond the recorded byte count read as the fill value instead.
module lz77_triple_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lz77td_pkg::t_dist    i_distance,
    input  lz77td_pkg::t_len     i_match_length,
    input  lz77td_pkg::t_byte    i_next_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output lz77td_pkg::t_byte    o_data_byte,
    output logic                 o_last,
    output logic                 o_malformed
);

    import lz77td_pkg::*;

    // sequencer
    t_state r_state, n_state;
    t_ctl   ctl;

    // triple being worked on
    t_dist  r_dist;
    t_len   r_count;
    t_byte  r_lit;
    logic   r_bad;
    logic   r_rec_lit;
    logic   r_use_fill;

    // decoder state
    t_byte             r_fill;
    logic [DIST_W-1:0] r_bytes_written;
    t_addr             r_wr_pos;
    logic              r_started;

    // output register
    logic   r_out_valid;
    t_byte  r_out_byte;
    logic   r_out_last;
    logic   r_out_bad;

    logic   in_beat;
    logic   out_free;
    logic   in_bad;
    logic   in_copy;
    t_len   in_len;
    t_addr  rd_addr;
    t_byte  rd_data;
    t_byte  copy_byte;
    t_byte  wr_byte;

    assign in_beat  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // zero distance with a length, or reaching past the window
    assign in_bad  = ((i_distance == '0) && (i_match_length != '0))
                  || (i_distance > DIST_W'(WINDOW_SIZE));
    assign in_copy = (i_distance != '0) && (i_match_length != '0);
    assign in_len  = (i_match_length > LEN_W'(MAX_MATCH)) ? LEN_W'(MAX_MATCH)
                                                           : i_match_length;

    // ring address distance bytes back; the window is a power of two
    assign rd_addr   = r_wr_pos - r_dist[ADDR_W-1:0];
    assign copy_byte = r_use_fill ? r_fill : rd_data;
    assign wr_byte   = ctl.load_copy ? copy_byte : r_lit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (r_started && !in_bad && in_copy) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_LIT;
                    end
                end
            end
            S_READ: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = (r_count == LEN_W'(1)) ? S_LIT : S_READ;
                end
            end
            S_LIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        ctl = '0;
        unique case (r_state)
            S_IDLE: ;
            S_READ: begin
                ctl.rd_en = 1'b1;
            end
            S_WAIT: begin
                ctl.load_copy = out_free;
                ctl.rec       = out_free;
            end
            S_LIT: begin
                ctl.load_lit = out_free;
                ctl.rec      = out_free && r_rec_lit;
            end
            default: ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_started       <= 1'b0;
            r_fill          <= '0;
            r_bytes_written <= '0;
            r_wr_pos        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_beat && !r_started) begin
                r_started <= 1'b1;
                r_fill    <= i_next_byte;
            end

            if (ctl.rec) begin
                r_wr_pos <= r_wr_pos + ADDR_W'(1);
                if (r_bytes_written != DIST_W'(WINDOW_SIZE)) begin
                    r_bytes_written <= r_bytes_written + DIST_W'(1);
                end
            end

            if (ctl.load_copy || ctl.load_lit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_dist    <= i_distance;
            r_count   <= in_len;
            r_lit     <= i_next_byte;
            r_bad     <= r_started && in_bad;
            // the first triple sets the fill value and its literal is not recorded
            r_rec_lit <= r_started;
        end
        if (ctl.rd_en) begin
            r_use_fill <= r_dist > r_bytes_written;
        end
        if (ctl.load_copy) begin
            r_count <= r_count - LEN_W'(1);
        end
        if (ctl.load_copy || ctl.load_lit) begin
            r_out_byte <= wr_byte;
            r_out_last <= ctl.load_lit;
            r_out_bad  <= ctl.load_lit && r_bad;
        end
    end

    lz77td_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (ctl.rec),
        .i_wr_addr (r_wr_pos),
        .i_wr_data (wr_byte),
        .i_rd_en   (ctl.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data_byte = r_out_byte;
    assign o_last      = r_out_last;
    assign o_malformed = r_out_bad;

endmodule

// ===== rtl/lz77td_checker.sv =====
// lz77td_checker: port-level assertions for the lz77 triple decoder
// depends on lz77td_pkg; bound to lz77_triple_decoder
`timescale 1ns / 1ps

module lz77td_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic              o_valid,
    input  logic              i_stall,
    input  lz77td_pkg::t_byte o_data_byte,
    input  logic              o_last,
    input  logic              o_malformed
);

    import lz77td_pkg::*;

    // a rejected triple gives a single byte
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_malformed) |-> o_last)
        else $error("malformed beat without last");

    // a taken triple blocks the input until it has been expanded
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not held off after a triple was taken");

    // a byte that is not the last leaves its triple still in flight
    a_mid_triple_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_stall)
        else $error("input open in the middle of a triple");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data_byte)
                                  && $stable(o_last) && $stable(o_malformed)))
        else $error("stalled output beat changed");

endmodule

bind lz77_triple_decoder lz77td_checker u_lz77td_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_data_byte (o_data_byte),
    .o_last      (o_last),
    .o_malformed (o_malformed)
);

// ===== verif/lz77_triple_decoder_tb.sv =====
// lz77_triple_decoder_tb: self-checking bench for the lz77 triple decoder
// depends on lz77td_pkg and the lz77_triple_decoder rtl; predicts every output
// beat from its own copy of the history ring and checks beats in order
`timescale 1ns / 1ps

module lz77_triple_decoder_tb;

    import lz77td_pkg::*;

    // one expected output beat
    typedef struct packed {
        t_byte data;
        logic  last;
        logic  bad;
    } t_out_beat;

    // clock, reset and block inputs, all known from time zero
    logic  i_clk          = 1'b0;
    logic  i_rst_n        = 1'b0;
    logic  i_valid        = 1'b0;
    t_dist i_distance     = '0;
    t_len  i_match_length = '0;
    t_byte i_next_byte    = '0;
    logic  i_stall        = 1'b0;

    logic  o_stall;
    logic  o_valid;
    t_byte o_data_byte;
    logic  o_last;
    logic  o_malformed;

    // decoder copy: history ring, fill byte, recorded count, write pointer
    t_byte hist_mem [WINDOW_SIZE];
    t_byte fill_byte   = '0;
    int    rec_count   = 0;
    t_addr wr_ptr      = '0;
    logic  seen_first  = 1'b0;

    // bytes the decoder still owes us, oldest first
    t_out_beat pending_bytes [$];
    int        n_errors = 0;

    // idling switches: when set, each side draws a random wait per beat
    logic gap_on   = 1'b0;
    logic stall_on = 1'b0;
    int   stall_left = 0;
    t_out_beat want;

    always #1 i_clk = ~i_clk;

    lz77_triple_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_distance     (i_distance),
        .i_match_length (i_match_length),
        .i_next_byte    (i_next_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last),
        .o_malformed    (o_malformed)
    );

    // add one byte to the ring; the count saturates once the window is full
    function automatic void record_byte(input t_byte b);
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (rec_count < WINDOW_SIZE) rec_count++;
    endfunction

    // work out the bytes one accepted triple expands to and queue them
    function automatic void decode_triple(input t_dist back, input t_len run_len,
                                          input t_byte lit);
        int        n_copy;
        t_byte     b;
        t_out_beat beat;
        n_copy = (run_len > MAX_MATCH) ? MAX_MATCH : int'(run_len);
        // very first triple sets the fill byte and gives its literal, nothing is recorded
        if (!seen_first) begin
            seen_first = 1'b1;
            fill_byte  = lit;
            beat = '{data: lit, last: 1'b1, bad: 1'b0};
            pending_bytes.push_back(beat);
            return;
        end
        // zero distance with a length, or reaching past the window: rejected
        if ((back == 0 && run_len != 0) || back > WINDOW_SIZE) begin
            record_byte(lit);
            beat = '{data: lit, last: 1'b1, bad: 1'b1};
            pending_bytes.push_back(beat);
            return;
        end
        if (back != 0) begin
            for (int k = 0; k < n_copy; k++) begin
                // beyond what has been recorded the window reads as the fill byte
                if (back > rec_count)
                    b = fill_byte;
                else
                    b = hist_mem[t_addr'(int'(wr_ptr) - int'(back))];
                record_byte(b);
                beat = '{data: b, last: 1'b0, bad: 1'b0};
                pending_bytes.push_back(beat);
            end
        end
        record_byte(lit);
        beat = '{data: lit, last: 1'b1, bad: 1'b0};
        pending_bytes.push_back(beat);
    endfunction

    // present one triple after an optional gap and hold it until taken;
    // valid is only lowered when a gap is drawn, so back-to-back beats
    // never see a low/high pair on i_valid in the same step
    task automatic send_triple(input t_dist back, input t_len run_len, input t_byte lit);
        int gap;
        gap = gap_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_distance     <= back;
        i_match_length <= run_len;
        i_next_byte    <= lit;
        // o_stall read here is the value from before the edge
        do @(posedge i_clk); while (o_stall);
        decode_triple(back, run_len, lit);
    endtask

    // output side: check every taken beat, then draw the next stall stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual byte %h last %b bad %b",
                         $time, o_data_byte, o_last, o_malformed);
                n_errors++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_data_byte !== want.data) begin
                    $display("%0t: data_byte expected %h actual %h",
                             $time, want.data, o_data_byte);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                    n_errors++;
                end
                if (o_malformed !== want.bad) begin
                    $display("%0t: malformed expected %b actual %b",
                             $time, want.bad, o_malformed);
                    n_errors++;
                end
            end
            stall_left = stall_on ? $urandom_range(0, 7) : 0;
            i_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= (stall_left != 0);
        end
    end

    // first triple after reset: distance and length are ignored,
    // the literal becomes the fill byte of the whole window
    task automatic test_first_triple();
        send_triple(13'h1FFF, 6'd63, 8'h5A);
    endtask

    // copies that reach back past recorded bytes pick up the fill byte
    task automatic test_fill_region();
        send_triple(13'd1, 6'd4, 8'h00);
        send_triple(13'd4096, 6'd3, 8'hFF);
        send_triple(13'd20, 6'd2, 8'h11);
    endtask

    // plain literals, with zero and with nonzero distance
    task automatic test_literals();
        send_triple(13'd0, 6'd0, 8'h00);
        send_triple(13'd0, 6'd0, 8'hFF);
        send_triple(13'd7, 6'd0, 8'h3C);
        send_triple(13'd4096, 6'd0, 8'hC3);
    endtask

    // rejected triples: zero distance with a length, distance past the window
    task automatic test_malformed();
        send_triple(13'd0, 6'd1, 8'h81);
        send_triple(13'd0, 6'd63, 8'h7E);
        send_triple(13'd4097, 6'd5, 8'h42);
        send_triple(13'h1FFF, 6'd0, 8'h24);
        send_triple(13'h1FFF, 6'd63, 8'hE7);
    endtask

    // real copies, overlapping ones and the longest match among them
    task automatic test_copies();
        send_triple(13'd1, 6'd63, 8'h99);
        send_triple(13'd3, 6'd10, 8'h55);
        send_triple(13'd2, 6'd63, 8'hAA);
        send_triple(13'd10, 6'd1, 8'h01);
        send_triple(13'd64, 6'd63, 8'h80);
    endtask

    // long copies until the ring wraps and the count saturates,
    // then reach the oldest slot with a full-window distance
    task automatic test_window_wrap();
        int span;
        for (int k = 0; k < 70; k++) begin
            span = (rec_count < WINDOW_SIZE) ? rec_count : WINDOW_SIZE;
            send_triple(t_dist'($urandom_range(1, span)), 6'd63,
                        t_byte'($urandom_range(0, 255)));
        end
        send_triple(13'd4096, 6'd5, 8'h6D);
        send_triple(13'd4096, 6'd63, 8'h92);
        send_triple(13'd4095, 6'd63, 8'h17);
    endtask

    // mostly well-formed copies with random content, some reaching past the
    // recorded bytes, some literals and some rejected triples
    task automatic test_random(input int n_items);
        int    pick;
        int    span;
        t_dist back;
        t_len  run_len;
        for (int k = 0; k < n_items; k++) begin
            // switch idling on and off in stretches
            if (k % 32 == 0) begin
                gap_on   = 1'($urandom_range(0, 1));
                stall_on = 1'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            span = (rec_count < WINDOW_SIZE) ? rec_count : WINDOW_SIZE;
            if (span == 0) span = 1;
            if (pick < 10)
                run_len = '0;
            else if (pick < 80)
                run_len = t_len'($urandom_range(1, 12));
            else
                run_len = t_len'($urandom_range(13, 63));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                back = t_dist'($urandom_range(1, (span < 64) ? span : 64));
            else if (pick < 70)
                back = t_dist'($urandom_range(1, span));
            else if (pick < 80)
                back = t_dist'($urandom_range(1, WINDOW_SIZE));
            else if (pick < 88) begin
                back    = '0;
                run_len = '0;
            end else if (pick < 94) begin
                back    = '0;
                run_len = t_len'($urandom_range(1, 63));
            end else
                back = t_dist'($urandom_range(WINDOW_SIZE + 1, 8191));
            send_triple(back, run_len, t_byte'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        // reset once, at the start
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part back to back, then with idling on both sides, then back to back again
        test_first_triple();
        test_fill_region();
        test_literals();
        gap_on   = 1'b1;
        stall_on = 1'b1;
        test_malformed();
        test_copies();
        gap_on   = 1'b0;
        stall_on = 1'b0;
        test_window_wrap();
        test_random(240);
        i_valid <= 1'b0;

        // drain, then give the block time to show any extra beat
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_MATCH + 16) @(posedge i_clk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
